>>> hw/rtl/sobel_pkg.sv
`default_nettype none
package sobel_pkg;
   localparam int MaxWidthDefault  = 1024;
   localparam int MaxHeightDefault = 4096;
   localparam int PixW = 24;
   localparam int ChanW = 8;
   localparam int CfgDataW = 13;
   localparam int CfgIdxW = 1;
   localparam logic [CfgIdxW-1:0] REG_WIDTH  = 1'b0;
   localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'b1;
   localparam logic [10:0] WidthReset  = 11'd640;
   localparam logic [12:0] HeightReset = 13'd480;
   localparam logic [7:0] SatMax = 8'd255;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       drain;
   } req_type;

   typedef struct packed {
      logic [7:0] edge_red;
      logic [7:0] edge_green;
      logic [7:0] edge_blue;
      logic       frame_last;
   } rsp_type;
endpackage
`default_nettype wire

>>> hw/rtl/sobel_stream_if.sv
`default_nettype none
interface sobel_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sobel_edge_magnitude_rgb_unit.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order.
// req channel: one pixel (red, green, blue) or a drain stand-in per transfer.
// rsp channel: per-channel magnitude round(sqrt(Gx^2+Gy^2)) saturated to 255,
//   with frame_last on the final pixel of the frame.
// The result for pixel (R,C) follows the transfer at frame position R*W+C+W+1,
//   so W+1 drain transfers flush a frame.
// Sequential: a new item is taken only once the last one is done and its result,
//   if any, is in the output register. Each item reads the line stores, shifts
//   the window, starts the lanes, then three lanes, one per colour, each step its
//   own root search over 255 candidates, one per cycle.
// A finished result waits in the output register. While the receiver stalls the
//   next item is still taken and its result held back; after that no further
//   item is taken until the output register frees.
// csr_: write enable, index (0 width, 1 height), data; write only while idle.
// Reset (synchronous): size 640x480, position zero, window cleared.
//   The line stores are not cleared; reads are masked by position.
`default_nettype none
module sobel_edge_magnitude_rgb_unit #(
   parameter int MAX_WIDTH  = sobel_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = sobel_pkg::MaxHeightDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   sobel_stream_if.sink   req,
   sobel_stream_if.source rsp,
   input  wire logic                           csr_write_enable,
   input  wire logic [sobel_pkg::CfgIdxW-1:0]  csr_index,
   input  wire logic [sobel_pkg::CfgDataW-1:0] csr_write_data
);
   import sobel_pkg::*;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = WW + HW + 1;
   localparam logic [1:0] ST_IDLE = 2'd0, ST_READ = 2'd1, ST_CALC = 2'd2, ST_OUT = 2'd3;

   logic [10:0] width_reg_ff;
   logic [12:0] height_reg_ff;
   logic [PW-1:0] w_ext, h_ext;
   logic [WW-1:0] w_c;
   logic [HW-1:0] h_c;
   logic [PW-1:0] total_p, flush_end;

   logic [1:0] state_ff;
   logic [PW-1:0] pos_ff, p_ff;
   logic [WW-1:0] col_ff, ocol_ff;
   logic [HW-1:0] row_ff;
   logic [PixW-1:0] upper_mem [MAX_WIDTH];
   logic [PixW-1:0] lower_mem [MAX_WIDTH];
   logic [PixW-1:0] up_rd_ff, lo_rd_ff, x_ff;
   logic [PixW-1:0] win_ff [9];
   logic emit_ff, last_ff;
   logic [CW-1:0] addr;
   logic [2:0] lane_done;
   logic [7:0] lane_mag [3];
   logic [71:0] lane_win [3];
   logic lane_start;
   logic start_ff;
   rsp_type res_ff;
   rsp_type out_ff;
   logic rsp_valid_ff;

   always_comb begin
      w_c = (width_reg_ff == '0) ? WW'(1) :
            (32'(width_reg_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg_ff);
      h_c = (height_reg_ff == '0) ? HW'(1) :
            (32'(height_reg_ff) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg_ff);
      w_ext = PW'(w_c);
      h_ext = PW'(h_c);
      total_p = PW'(w_ext * h_ext);
      flush_end = total_p + w_ext;
      // Restart the frame at column zero when the size shrank under the position.
      addr = (state_ff == ST_IDLE && pos_ff > flush_end) ? '0 : col_ff[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff <= WidthReset;
         height_reg_ff <= HeightReset;
      end else if (csr_write_enable) begin
         if (csr_index == REG_WIDTH) width_reg_ff <= csr_write_data[10:0];
         else if (csr_index == REG_HEIGHT) height_reg_ff <= csr_write_data;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   // Start the lanes once the window and output position have advanced.
   assign lane_start = start_ff;

   // Window rows top, middle, bottom; columns left, centre, right. Masked per position.
   always_comb begin
      logic ok;
      for (int ch = 0; ch < 3; ch++) begin
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
               ok = 1'b1;
               if (a == 0 && row_ff == '0) ok = 1'b0;
               if (a == 2 && (PW'(row_ff) + 1'b1) >= h_ext) ok = 1'b0;
               if (b == 0 && ocol_ff == '0) ok = 1'b0;
               if (b == 2 && (PW'(ocol_ff) + 1'b1) >= w_ext) ok = 1'b0;
               lane_win[ch][(a*3+b)*8 +: 8] = ok ? win_ff[a*3+b][ch*8 +: 8] : 8'd0;
            end
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      sobel_lane u_lane (.clock(clock), .reset(reset), .start(lane_start),
         .win(lane_win[g]), .done(lane_done[g]), .mag(lane_mag[g]));
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.valid) begin
         up_rd_ff <= upper_mem[addr];
         lo_rd_ff <= lower_mem[addr];
      end
      if (state_ff == ST_READ) begin
         upper_mem[addr] <= lo_rd_ff;
         lower_mem[addr] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0; col_ff <= '0; ocol_ff <= '0; row_ff <= '0;
         rsp_valid_ff <= 1'b0;
         emit_ff <= 1'b0;
         start_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         start_ff <= (state_ff == ST_READ);
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  // Restart the frame when the size shrank under the position.
                  if (pos_ff > flush_end) begin
                     p_ff <= '0;
                     col_ff <= '0;
                  end else p_ff <= pos_ff;
                  x_ff <= (req.payload.drain || (pos_ff <= flush_end && pos_ff >= total_p)) ?
                          '0 : {req.payload.blue, req.payload.green, req.payload.red};
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               for (int i = 0; i < 3; i++) begin
                  win_ff[i*3] <= win_ff[i*3+1];
                  win_ff[i*3+1] <= win_ff[i*3+2];
               end
               win_ff[2] <= up_rd_ff;
               win_ff[5] <= lo_rd_ff;
               win_ff[8] <= x_ff;
               emit_ff <= p_ff >= w_ext + 1'b1;
               last_ff <= (p_ff == flush_end);
               if (p_ff >= w_ext + 1'b1) begin
                  if (ocol_ff + 1'b1 == w_c || p_ff == w_ext + 1'b1) begin
                     ocol_ff <= '0;
                     row_ff <= (p_ff == w_ext + 1'b1) ? '0 : row_ff + 1'b1;
                  end else ocol_ff <= ocol_ff + 1'b1;
               end
               if (p_ff == flush_end) begin
                  pos_ff <= '0; col_ff <= '0;
               end else begin
                  pos_ff <= p_ff + 1'b1;
                  col_ff <= (col_ff + 1'b1 == w_c) ? '0 : col_ff + 1'b1;
               end
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               // The three lanes always finish together; merge their results.
               if (lane_done[0]) begin
                  res_ff.edge_red <= lane_mag[0];
                  res_ff.edge_green <= lane_mag[1];
                  res_ff.edge_blue <= lane_mag[2];
                  res_ff.frame_last <= last_ff;
                  state_ff <= emit_ff ? ST_OUT : ST_IDLE;
               end
            end
            ST_OUT: begin
               // Hold the result until the output register frees.
               if (!rsp_valid_ff || rsp.ready) begin
                  out_ff <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = out_ff;

`ifndef SYNTHESIS
   a_lanes_sync: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
      else $error("lanes out of step");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("accept while busy");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> pos_ff <= flush_end)
      else $error("position past flush point");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/sobel_lane.sv
`default_nettype none
// One colour channel: gradients, squared sum, then a 255-step iterative root.
module sobel_lane (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [9*8-1:0]      win,
   output logic                     done,
   output logic [7:0]               mag
);
   import sobel_pkg::*;
   logic signed [11:0] gx, gy;
   logic [20:0] sum_ff, sum_in;
   logic [8:0]  k_ff, k_in;
   logic [7:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [16:0] prod;
   function automatic logic signed [11:0] px(input logic [71:0] w, input int i);
      return $signed({4'b0, w[i*8 +: 8]});
   endfunction
   always_comb begin
      gx = (px(win,2) + 12'sd2*px(win,5) + px(win,8)) - (px(win,0) + 12'sd2*px(win,3) + px(win,6));
      gy = (px(win,6) + 12'sd2*px(win,7) + px(win,8)) - (px(win,0) + 12'sd2*px(win,1) + px(win,2));
      prod = 17'(k_ff) * 17'(k_ff - 9'd1);
      sum_in = sum_ff; k_in = k_ff; n_in = n_ff; busy_in = busy_ff;
      if (start) begin
         sum_in = 21'(gx*gx) + 21'(gy*gy);
         k_in = 9'd1; n_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (21'(prod) < sum_ff) n_in = k_ff[7:0];
         if (k_ff[7:0] == SatMax) busy_in = 1'b0;
         k_in = k_ff + 9'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      sum_ff <= sum_in; k_ff <= k_in; n_ff <= n_in;
   end
   assign done = busy_ff && k_ff[7:0] == SatMax;
   assign mag  = (21'(prod) < sum_ff) ? k_ff[7:0] : n_ff;
endmodule
`default_nettype wire

>>> verif/sobel_edge_scoreboard.sv
`default_nettype none
module sobel_edge_scoreboard (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire sobel_pkg::req_type             req_payload,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire sobel_pkg::rsp_type             rsp_payload,
   input  wire logic                           csr_write_enable,
   input  wire logic [sobel_pkg::CfgIdxW-1:0]  csr_index,
   input  wire logic [sobel_pkg::CfgDataW-1:0] csr_write_data,
   output int unsigned                         fail_count,
   output int unsigned                         pending_count
);
   import sobel_pkg::*;

   localparam int unsigned LineDepth = MaxWidthDefault;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   logic [10:0] width_reg;
   logic [12:0] height_reg;
   rgb_type     row_older [LineDepth];
   rgb_type     row_newer [LineDepth];
   rgb_type     window [3][3];
   int unsigned frame_pos;
   rsp_type     edge_queue [$];

   initial fail_count = 0;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int sample(input rgb_type p, input int lane);
      case (lane)
         0: return int'(p.red);
         1: return int'(p.green);
         default: return int'(p.blue);
      endcase
   endfunction

   // rounded root, half up: floor root r, then bump when s exceeds r*r + r
   function automatic logic [7:0] edge_magnitude(input rgb_type m [3][3], input int lane);
      int gx, gy;
      int unsigned s, r, bitv;
      gx = (sample(m[0][2], lane) + 2 * sample(m[1][2], lane) + sample(m[2][2], lane))
         - (sample(m[0][0], lane) + 2 * sample(m[1][0], lane) + sample(m[2][0], lane));
      gy = (sample(m[2][0], lane) + 2 * sample(m[2][1], lane) + sample(m[2][2], lane))
         - (sample(m[0][0], lane) + 2 * sample(m[0][1], lane) + sample(m[0][2], lane));
      s = gx * gx + gy * gy;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
         bitv = r | (1 << b);
         if (bitv * bitv <= s) r = bitv;
      end
      if (s > r * r + r) r++;
      if (r > 255) r = 255;
      return r[7:0];
   endfunction

   task automatic advance_pixel(input req_type item);
      int unsigned w, h, total, flush_end, p, c, q, rr, cc;
      rgb_type x;
      rgb_type col [3];
      rgb_type m [3][3];
      rsp_type r;
      bit keep;
      w = clamp_dim(width_reg, MaxWidthDefault);
      h = clamp_dim(height_reg, MaxHeightDefault);
      total = w * h;
      flush_end = total + w;
      if (frame_pos > flush_end) frame_pos = 0;
      p = frame_pos;
      c = p % w;
      x = '{blue: item.blue, green: item.green, red: item.red};
      if (item.drain || p >= total) x = '0;
      col[0] = row_older[c];
      col[1] = row_newer[c];
      col[2] = x;
      row_older[c] = row_newer[c];
      row_newer[c] = x;
      for (int i = 0; i < 3; i++) begin
         window[i][0] = window[i][1];
         window[i][1] = window[i][2];
         window[i][2] = col[i];
      end
      if (p >= w + 1) begin
         q = p - w - 1;
         rr = q / w;
         cc = q % w;
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
               keep = !((a == 0 && rr == 0) || (a == 2 && rr + 1 >= h) ||
                        (b == 0 && cc == 0) || (b == 2 && cc + 1 >= w));
               m[a][b] = keep ? window[a][b] : '0;
            end
         end
         r.edge_red   = edge_magnitude(m, 0);
         r.edge_green = edge_magnitude(m, 1);
         r.edge_blue  = edge_magnitude(m, 2);
         r.frame_last = (q == total - 1);
         edge_queue.push_back(r);
      end
      frame_pos = (p == flush_end) ? 0 : p + 1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         width_reg  = WidthReset;
         height_reg = HeightReset;
         frame_pos  = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               window[i][j] = '0;
         edge_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_WIDTH) width_reg = csr_write_data[10:0];
            else if (csr_index == REG_HEIGHT) height_reg = csr_write_data[12:0];
         end
         if (req_valid && req_ready) advance_pixel(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (edge_queue.size() == 0) begin
               $error("unexpected result transfer");
               fail_count++;
            end else begin
               want = edge_queue.pop_front();
               if (rsp_payload.edge_red !== want.edge_red) begin
                  $error("edge_red expected %0d got %0d", want.edge_red, rsp_payload.edge_red);
                  fail_count++;
               end
               if (rsp_payload.edge_green !== want.edge_green) begin
                  $error("edge_green expected %0d got %0d",
                         want.edge_green, rsp_payload.edge_green);
                  fail_count++;
               end
               if (rsp_payload.edge_blue !== want.edge_blue) begin
                  $error("edge_blue expected %0d got %0d",
                         want.edge_blue, rsp_payload.edge_blue);
                  fail_count++;
               end
               if (rsp_payload.frame_last !== want.frame_last) begin
                  $error("frame_last expected %0d got %0d",
                         want.frame_last, rsp_payload.frame_last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = edge_queue.size();
   end
endmodule
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
module tb_top;
   import sobel_pkg::*;

   // generous: every item at its slowest plus both sides at their longest idle, several times over
   localparam int unsigned CycleLimit = 12_000_000;
   localparam int unsigned SettleCycles = 400;
   localparam int unsigned RandomItems = 1350;

   logic clock;
   logic reset;
   logic                csr_write_enable;
   logic [CfgIdxW-1:0]  csr_index;
   logic [CfgDataW-1:0] csr_write_data;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned ready_hold;
   bit          quiet;

   sobel_stream_if #(.payload_type(req_type)) req_chan ();
   sobel_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   sobel_edge_magnitude_rgb_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   sobel_edge_scoreboard scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_payload      (req_chan.payload),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_payload      (rsp_chan.payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: give up if the block wedges.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver back-pressure: mostly short stalls, the odd long one; no new ones while quiet.
   initial ready_hold = 0;
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                  : $urandom_range(0, 3);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Sample with a bias towards the extremes so saturation gets hit.
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Drive one transfer, with an optional gap first; return once accepted.
   task automatic send_pixel(input bit drain_item);
      req_type item;
      int unsigned gap;
      item.red   = pick_sample();
      item.green = pick_sample();
      item.blue  = pick_sample();
      item.drain = drain_item;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Hold off until every expected result is back and the block has settled.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // One frame from position zero: pixels (some drained), then the W+1 flush
   // transfers, with real_tail partly real pixels past the frame which must count as zero.
   task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg,
                            input int unsigned drain_pct, input bit real_tail);
      int unsigned w, h;
      wait_drained();
      write_reg(REG_WIDTH, CfgDataW'(w_reg));
      write_reg(REG_HEIGHT, CfgDataW'(h_reg));
      w = (w_reg[10:0] == 0) ? 1 : ((w_reg[10:0] > MaxWidthDefault) ? MaxWidthDefault
                                                                     : w_reg[10:0]);
      h = (h_reg[12:0] == 0) ? 1 : ((h_reg[12:0] > MaxHeightDefault) ? MaxHeightDefault
                                                                     : h_reg[12:0]);
      for (int unsigned i = 0; i < w * h; i++)
         send_pixel($urandom_range(1, 100) <= drain_pct);
      for (int unsigned i = 0; i <= w; i++)
         send_pixel(real_tail ? $urandom_range(0, 1) : 1'b1);
   endtask

   initial begin
      int unsigned w_reg, h_reg;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_WIDTH;
      csr_write_data   <= '0;
      quiet = 1'b0;
      items_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single pixel frame, zero sizes clamped up, small frames with drains
      run_frame(1, 1, 0, 1'b1);
      run_frame(0, 0, 0, 1'b1);
      run_frame(3, 3, 20, 1'b1);
      run_frame(2, 1, 50, 1'b0);

      // oversized height clamps; overwrite before any transfer to keep the run short
      wait_drained();
      write_reg(REG_HEIGHT, 13'h1FFF);
      run_frame(4, 2, 0, 1'b0);

      while (items_sent < RandomItems) begin
         quiet = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 19))
            0, 1, 2:  w_reg = $urandom_range(9, 40);
            3:        w_reg = 0;
            default:  w_reg = $urandom_range(1, 8);
         endcase
         h_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
         // junk in the unused upper data bits must be ignored
         w_reg = w_reg[10:0] | (($urandom_range(0, 3) == 0) ? 32'h1800 : 32'h0);
         run_frame(w_reg, h_reg, $urandom_range(0, 3) == 0 ? 30 : 5, $urandom_range(0, 1));
      end
      quiet = 1'b0;

      wait_drained();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
